### rtl/jue_pkg.sv
`default_nettype none

package jue_pkg;

  // input and result payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       run_last;
  } out_item_t;

  // how one source byte expands into output characters
  typedef enum logic [1:0] {
    KIND_RAW,   // the byte itself
    KIND_PAIR,  // backslash, then the stored character
    KIND_UHEX   // backslash u 0 0 hi lo
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] ch;
  } slot_t;

  localparam int unsigned JOB_SLOTS = 4;
  localparam int unsigned SLOT_AW   = $clog2(JOB_SLOTS);

  // everything one accepted byte causes: up to three held bytes plus itself
  typedef struct packed {
    slot_t [JOB_SLOTS-1:0] slots;
    logic  [SLOT_AW-1:0]   last_slot;
  } job_t;

  // queue between front and back, depth a power of two
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_U       = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

endpackage

`default_nettype wire

### rtl/jue_front.sv
`default_nettype none

module jue_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire jue_pkg::in_item_t in_item_i,
  output logic                  in_stall_o,
  output logic                  push_o,
  output jue_pkg::job_t         job_o,
  input  wire logic             full_i
);

  logic [7:0] held_q [3];
  logic [1:0] held_cnt_q, held_cnt_d;
  logic [2:0] exp_len_q, exp_len_d;

  logic        accept;
  logic [7:0]  b;
  logic        eob;
  logic        is_cont;
  logic        complete;
  logic        seq_ok;
  logic [10:0] cp2;
  logic [15:0] cp3;
  logic [20:0] cp4;

  jue_pkg::kind_e fr_kind;
  logic [7:0]     fr_ch;
  logic           fr_hold;
  logic [2:0]     fr_len;

  logic       hold_wr;
  logic [1:0] hold_idx;
  logic [2:0] n_slots;
  jue_pkg::job_t job;

  assign b          = in_item_i.data_byte;
  assign eob        = in_item_i.end_of_buffer;
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_cont    = (b[7:6] == 2'b10);
  assign complete   = (({1'b0, held_cnt_q} + 3'd1) == exp_len_q);

  // code point of the sequence closed by this byte
  assign cp2 = {held_q[0][4:0], b[5:0]};
  assign cp3 = {held_q[0][3:0], held_q[1][5:0], b[5:0]};
  assign cp4 = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0], b[5:0]};

  always_comb begin
    case (exp_len_q)
      3'd2:    seq_ok = (cp2 >= 11'h080);
      3'd3:    seq_ok = (cp3 >= 16'h0800) && !((cp3 >= 16'hD800) && (cp3 <= 16'hDFFF));
      3'd4:    seq_ok = (cp4 >= 21'h010000) && (cp4 <= 21'h10FFFF);
      default: seq_ok = 1'b0;
    endcase
  end

  // byte seen with nothing held
  always_comb begin
    fr_kind = jue_pkg::KIND_UHEX;
    fr_ch   = b;
    fr_hold = 1'b0;
    fr_len  = 3'd0;
    if ((b & 8'hE0) == 8'hC0) begin
      fr_len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      fr_len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      fr_len = 3'd4;
    end
    case (b)
      8'h22:   begin fr_kind = jue_pkg::KIND_PAIR; fr_ch = 8'h22; end
      8'h5C:   begin fr_kind = jue_pkg::KIND_PAIR; fr_ch = 8'h5C; end
      8'h0A:   begin fr_kind = jue_pkg::KIND_PAIR; fr_ch = 8'h6E; end
      8'h0D:   begin fr_kind = jue_pkg::KIND_PAIR; fr_ch = 8'h72; end
      8'h09:   begin fr_kind = jue_pkg::KIND_PAIR; fr_ch = 8'h74; end
      8'h08:   begin fr_kind = jue_pkg::KIND_PAIR; fr_ch = 8'h62; end
      8'h0C:   begin fr_kind = jue_pkg::KIND_PAIR; fr_ch = 8'h66; end
      default: begin
        if (b inside {[8'd32:8'd126]}) begin
          fr_kind = jue_pkg::KIND_RAW;
        end else if (b[7] && (fr_len != 3'd0) && !eob) begin
          fr_hold = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    job        = '0;
    n_slots    = 3'd0;
    held_cnt_d = held_cnt_q;
    exp_len_d  = exp_len_q;
    hold_wr    = 1'b0;
    hold_idx   = held_cnt_q;
    if ((held_cnt_q != 2'd0) && is_cont) begin
      if (complete || eob || (held_cnt_q == 2'd3)) begin
        // sequence closed: pass as is when valid, else escape every byte
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < held_cnt_q) begin
            job.slots[k].kind = (complete && seq_ok) ? jue_pkg::KIND_RAW
                                                     : jue_pkg::KIND_UHEX;
            job.slots[k].ch   = held_q[k];
          end
        end
        job.slots[held_cnt_q].kind = (complete && seq_ok) ? jue_pkg::KIND_RAW
                                                          : jue_pkg::KIND_UHEX;
        job.slots[held_cnt_q].ch   = b;
        n_slots    = {1'b0, held_cnt_q} + 3'd1;
        held_cnt_d = 2'd0;
        exp_len_d  = 3'd0;
      end else begin
        hold_wr    = 1'b1;
        held_cnt_d = held_cnt_q + 2'd1;
      end
    end else begin
      // broken sequence (if any) escaped, then the byte taken afresh
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < held_cnt_q) begin
          job.slots[k].kind = jue_pkg::KIND_UHEX;
          job.slots[k].ch   = held_q[k];
        end
      end
      if (fr_hold) begin
        hold_wr    = 1'b1;
        hold_idx   = 2'd0;
        held_cnt_d = 2'd1;
        exp_len_d  = fr_len;
        n_slots    = {1'b0, held_cnt_q};
      end else begin
        job.slots[held_cnt_q].kind = fr_kind;
        job.slots[held_cnt_q].ch   = fr_ch;
        n_slots    = {1'b0, held_cnt_q} + 3'd1;
        held_cnt_d = 2'd0;
        exp_len_d  = 3'd0;
      end
    end
    job.last_slot = jue_pkg::SLOT_AW'(n_slots - 3'd1);
  end

  assign job_o  = job;
  assign push_o = accept && (n_slots != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
    end else if (accept) begin
      held_cnt_q <= held_cnt_d;
      exp_len_q  <= exp_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hold_wr) begin
      for (int k = 0; k < 3; k++) begin
        if (hold_idx == 2'(k)) begin
          held_q[k] <= b;
        end
      end
    end
  end

  a_held_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_cnt_q != 2'd0) |-> ((exp_len_q >= 3'd2) && (exp_len_q <= 3'd4)
                              && ({1'b0, held_cnt_q} < exp_len_q)))
    else $error("held count out of step with expected length");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !full_i)
    else $error("push while queue full");

endmodule

`default_nettype wire

### rtl/jue_queue.sv
`default_nettype none

module jue_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire jue_pkg::job_t push_job_i,
  output logic               full_o,
  output logic               head_valid_o,
  output jue_pkg::job_t      head_job_o,
  input  wire logic          pop_i
);

  localparam logic [jue_pkg::QUEUE_AW:0] DepthC = (jue_pkg::QUEUE_AW+1)'(jue_pkg::QUEUE_DEPTH);

  jue_pkg::job_t mem_q [jue_pkg::QUEUE_DEPTH];
  logic [jue_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [jue_pkg::QUEUE_AW:0]   cnt_q;

  assign full_o       = (cnt_q == DepthC);
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthC)
    else $error("queue count overflow");

endmodule

`default_nettype wire

### rtl/jue_back.sv
`default_nettype none

module jue_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          src_valid_i,
  input  wire jue_pkg::job_t src_job_i,
  output logic               src_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output jue_pkg::out_item_t out_item_o
);

  localparam logic [2:0] UhexLast = 3'd5;

  logic [jue_pkg::SLOT_AW-1:0] slot_q;
  logic [2:0]                  pos_q;
  logic                        out_valid_q;
  jue_pkg::out_item_t          out_item_q;

  jue_pkg::slot_t cur;
  logic [7:0]     ch;
  logic           slot_end;
  logic           job_end;
  logic           load;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return {4'h0, v} + jue_pkg::CH_ZERO;
    end
    return ({4'h0, v} - 8'd10) + jue_pkg::CH_LOWER_A;
  endfunction

  assign cur = src_job_i.slots[slot_q];

  always_comb begin
    ch       = cur.ch;
    slot_end = 1'b1;
    case (cur.kind)
      jue_pkg::KIND_RAW: begin
        ch       = cur.ch;
        slot_end = 1'b1;
      end
      jue_pkg::KIND_PAIR: begin
        ch       = (pos_q == 3'd0) ? jue_pkg::CH_BSLASH : cur.ch;
        slot_end = (pos_q == 3'd1);
      end
      jue_pkg::KIND_UHEX: begin
        case (pos_q)
          3'd0:    ch = jue_pkg::CH_BSLASH;
          3'd1:    ch = jue_pkg::CH_U;
          3'd2:    ch = jue_pkg::CH_ZERO;
          3'd3:    ch = jue_pkg::CH_ZERO;
          3'd4:    ch = hex_char(cur.ch[7:4]);
          default: ch = hex_char(cur.ch[3:0]);
        endcase
        slot_end = (pos_q == UhexLast);
      end
      default: begin
        ch       = cur.ch;
        slot_end = 1'b1;
      end
    endcase
  end

  assign job_end   = slot_end && (slot_q == src_job_i.last_slot);
  assign load      = src_valid_i && (!out_valid_q || !out_stall_i);
  assign src_pop_o = load && job_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      pos_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (slot_end) begin
          pos_q  <= 3'd0;
          slot_q <= job_end ? '0 : slot_q + 1'b1;
        end else begin
          pos_q <= pos_q + 3'd1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q.out_char <= ch;
      out_item_q.run_last <= job_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_mid_job_has_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((pos_q != 3'd0) || (slot_q != '0)) |-> src_valid_i)
    else $error("expansion under way with no job at queue head");

endmodule

`default_nettype wire

### rtl/json_utf8_string_escaper.sv
// JSON string escaper with UTF-8 checking. Payload bytes come in one per
// transfer, each with an end-of-buffer mark, and leave as the characters of
// their JSON-string-escaped form, one character per transfer; run_last marks
// the final character that an input byte caused. Quote and backslash get a
// backslash in front, newline, carriage return, tab, backspace and form feed
// become two-character escapes, printable ASCII passes, other control bytes,
// DEL and any bad UTF-8 byte become \u00xx in lower-case hex. A UTF-8 lead
// byte and its continuation bytes are held inside and give no output until
// the sequence closes; then it leaves unchanged if valid, else escaped byte
// by byte. Rate: the input takes one transfer per cycle while the two-entry
// job queue has room; the output side emits one character per cycle unless
// stalled, so a byte gives 1 output character when passed, 2 for a short
// escape, 6 for \u00xx and up to 24 when a held sequence of four bytes is
// escaped. The expander's output character rate sets the sustained rate. A
// byte's job is registered in the queue, then each character at the output.
`default_nettype none

module json_utf8_string_escaper (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // byte input
  input  wire logic               in_valid_i,
  input  wire jue_pkg::in_item_t  in_item_i,
  output logic                    in_stall_o,
  // character output
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output jue_pkg::out_item_t      out_item_o
);

  // front to queue
  logic          push;
  jue_pkg::job_t push_job;
  logic          q_full;

  // queue to back
  logic          head_valid;
  jue_pkg::job_t head_job;
  logic          pop;

  // front: utf-8 tracking and classification of every byte into a job
  jue_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (q_full)
  );

  // short queue so the two sides stall on their own
  jue_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_job_o   (head_job),
    .pop_i        (pop)
  );

  // back: expands a job into characters behind a registered output
  jue_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .src_valid_i (head_valid),
    .src_job_i   (head_job),
    .src_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### bench/tb_json_utf8_string_escaper.sv
`timescale 1ns / 1ps

module tb_json_utf8_string_escaper;

  // ascii codes used by the escape rules
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BS    = 8'h08;  // backspace
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] LT_B     = 8'h62;
  localparam logic [7:0] LT_F     = 8'h66;
  localparam logic [7:0] LT_N     = 8'h6E;
  localparam logic [7:0] LT_R     = 8'h72;
  localparam logic [7:0] LT_T     = 8'h74;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid;
  jue_pkg::in_item_t  in_item;
  logic               in_stall;
  logic               out_valid;
  logic               out_stall;
  jue_pkg::out_item_t out_item;

  json_utf8_string_escaper dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_item_i   (in_item),
    .in_stall_o  (in_stall),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // characters still owed by the block, oldest first
  jue_pkg::out_item_t escaped_chars[$];
  // characters caused by the byte being predicted
  logic [7:0]  burst_chars[$];

  // predictor copy of the utf-8 holding state
  logic [7:0]  held_seq [3];
  int unsigned held_n;
  int unsigned seq_len;

  int          mismatch_count;
  int          bytes_sent;
  bit          idle_on;
  int          out_stall_left;
  jue_pkg::out_item_t want_item;

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? jue_pkg::CH_ZERO + 8'(v)
                       : jue_pkg::CH_LOWER_A + 8'(v) - 8'd10;
  endfunction

  // length that a lead byte announces, zero when it is no lead byte
  function automatic int unsigned lead_len(input logic [7:0] b);
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  // overlong, surrogate and out-of-range forms are rejected
  function automatic bit utf8_valid(input logic [7:0] b0, b1, b2, b3,
                                    input int unsigned len);
    logic [20:0] cp;
    case (len)
      2: begin
        cp = {10'd0, b0[4:0], b1[5:0]};
        return cp >= 21'h80;
      end
      3: begin
        cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        return cp >= 21'h800 && !(cp >= 21'hD800 && cp <= 21'hDFFF);
      end
      4: begin
        cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        return cp >= 21'h10000 && cp <= 21'h10FFFF;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic put_pair(input logic [7:0] ch);
    burst_chars.push_back(jue_pkg::CH_BSLASH);
    burst_chars.push_back(ch);
  endtask

  // \u00xx, lower-case hex
  task automatic put_uhex(input logic [7:0] b);
    burst_chars.push_back(jue_pkg::CH_BSLASH);
    burst_chars.push_back(jue_pkg::CH_U);
    burst_chars.push_back(jue_pkg::CH_ZERO);
    burst_chars.push_back(jue_pkg::CH_ZERO);
    burst_chars.push_back(hex_char(b[7:4]));
    burst_chars.push_back(hex_char(b[3:0]));
  endtask

  task automatic flush_held();
    int unsigned k;
    for (k = 0; k < held_n; k++) put_uhex(held_seq[k]);
    held_n  = 0;
    seq_len = 0;
  endtask

  // a byte seen with nothing held
  task automatic escape_fresh(input logic [7:0] b, input logic eob);
    case (b)
      CH_QUOTE, jue_pkg::CH_BSLASH: put_pair(b);
      CH_NL:  put_pair(LT_N);
      CH_CR:  put_pair(LT_R);
      CH_TAB: put_pair(LT_T);
      CH_BS:  put_pair(LT_B);
      CH_FF:  put_pair(LT_F);
      default: begin
        if (b >= CH_SPACE && b <= CH_TILDE) begin
          burst_chars.push_back(b);
        end else if (b[7] && lead_len(b) != 0 && !eob) begin
          held_seq[0] = b;
          held_n      = 1;
          seq_len     = lead_len(b);
        end else begin
          put_uhex(b);
        end
      end
    endcase
  endtask

  // works out every character one accepted byte causes
  task automatic escape_byte(input logic [7:0] b, input logic eob);
    logic [7:0]  seq [4];
    int unsigned k;
    burst_chars.delete();
    if (held_n != 0) begin
      if (b[7:6] == 2'b10) begin
        if (held_n + 1 == seq_len) begin
          for (k = 0; k < 4; k++) seq[k] = (k < held_n) ? held_seq[k] : b;
          if (utf8_valid(seq[0], seq[1], seq[2], seq[3], seq_len)) begin
            for (k = 0; k < held_n; k++) burst_chars.push_back(held_seq[k]);
            burst_chars.push_back(b);
            held_n  = 0;
            seq_len = 0;
          end else begin
            flush_held();
            put_uhex(b);
          end
        end else if (eob || held_n >= 3) begin
          // cut off by the end of the buffer
          flush_held();
          put_uhex(b);
        end else begin
          held_seq[held_n] = b;
          held_n++;
        end
      end else begin
        // broken sequence, breaking byte handled afresh
        flush_held();
        escape_fresh(b, eob);
      end
    end else begin
      escape_fresh(b, eob);
    end
    for (k = 0; k < burst_chars.size(); k++)
      escaped_chars.push_back('{out_char: burst_chars[k],
                                run_last: (k == burst_chars.size() - 1)});
  endtask

  // ---------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------

  // one byte transfer, with an occasional idle burst in front
  task automatic send_byte(input logic [7:0] b, input logic eob);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_item  <= '{data_byte: b, end_of_buffer: eob};
    // payload holds until the transfer happens
    do @(posedge clk_i); while (in_stall);
    escape_byte(b, eob);
    bytes_sent++;
  endtask

  // hold the input off until the block owes nothing
  task automatic wait_for_drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (escaped_chars.size() == 0);
  endtask

  function automatic logic rand_eob();
    return ($urandom_range(0, 7) == 0);
  endfunction

  function automatic logic [7:0] rand_lead(input int unsigned len);
    case (len)
      2:       return {3'b110, 5'($urandom)};
      3:       return {4'b1110, 4'($urandom)};
      default: return {5'b11110, 3'($urandom)};
    endcase
  endfunction

  function automatic logic [7:0] rand_cont();
    return {2'b10, 6'($urandom)};
  endfunction

  // mostly well-formed runs with random content, some noise, some breaks
  task automatic send_random_run(input int target);
    int unsigned pick;
    int unsigned len;
    int unsigned k;
    logic [7:0]  brk;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 19);
      len  = $urandom_range(1, 4);
      if (pick < 12) begin
        if (len == 1) begin
          send_byte(8'($urandom_range(0, 127)), rand_eob());
        end else begin
          send_byte(rand_lead(len), rand_eob());
          for (k = 1; k < len; k++) send_byte(rand_cont(), rand_eob());
        end
      end else if (pick < 17) begin
        send_byte(8'($urandom_range(0, 255)), rand_eob());
      end else begin
        // lead, too few continuation bytes, then a non-continuation byte
        if (len == 1) len = 2;
        send_byte(rand_lead(len), 1'b0);
        for (k = 0; k < $urandom_range(0, len - 2); k++) send_byte(rand_cont(), 1'b0);
        do brk = 8'($urandom); while (brk[7:6] == 2'b10);
        send_byte(brk, rand_eob());
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // output side
  // ---------------------------------------------------------------------

  // random stall bursts
  always @(negedge clk_i) begin
    if (out_stall_left > 0) begin
      out_stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_left = $urandom_range(1, 19) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // every character transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (escaped_chars.size() == 0) begin
        $error("unexpected transfer: out_char %h run_last %b",
               out_item.out_char, out_item.run_last);
        mismatch_count++;
      end else begin
        want_item = escaped_chars.pop_front();
        if (out_item.out_char !== want_item.out_char) begin
          $error("out_char: expected %h, got %h", want_item.out_char, out_item.out_char);
          mismatch_count++;
        end
        if (out_item.run_last !== want_item.run_last) begin
          $error("run_last: expected %b, got %b", want_item.run_last, out_item.run_last);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // short escapes, pass-through and \u00xx for control bytes
  task automatic test_ascii_escapes();
    send_byte(8'h00, 1'b0);      // zero byte
    send_byte(CH_DEL, 1'b0);
    send_byte(CH_SPACE, 1'b0);
    send_byte(CH_TILDE, 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(jue_pkg::CH_BSLASH, 1'b0);
    send_byte(CH_NL, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_BS, 1'b0);
    send_byte(CH_FF, 1'b1);
  endtask

  // lead byte forms, validity limits, breaks and cut-offs
  task automatic test_utf8_cases();
    send_byte(8'hC2, 1'b0);      // smallest valid two-byte form
    send_byte(8'h80, 1'b0);
    send_byte(8'hED, 1'b0);      // surrogate
    send_byte(8'hA0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF4, 1'b0);      // just above the code point limit
    send_byte(8'h90, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC1, 1'b0);      // overlong
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b0);      // broken by a plain letter
    send_byte(8'h41, 1'b0);
    send_byte(8'hF0, 1'b0);      // cut off by a marked continuation byte
    send_byte(8'h9F, 1'b1);
    send_byte(8'hC3, 1'b1);      // lead byte at the end of the buffer
    send_byte(8'h80, 1'b0);      // stray continuation byte
    send_byte(8'hFF, 1'b0);      // never a lead byte
  endtask

  task automatic test_random_traffic();
    send_random_run(bytes_sent + 120);
  endtask

  // sender waits for the block to empty, then carries on
  task automatic test_drain_pause();
    wait_for_drain();
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_for_drain();
  endtask

  // back-to-back transfers, no idling on either side
  task automatic test_full_rate();
    idle_on = 1'b0;
    send_random_run(bytes_sent + 60);
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    out_stall      = 1'b0;
    out_stall_left = 0;
    idle_on        = 1'b1;
    mismatch_count = 0;
    bytes_sent     = 0;
    held_seq       = '{default: 8'h00};
    held_n         = 0;
    seq_len        = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_ascii_escapes();
    test_utf8_cases();
    test_random_traffic();
    test_drain_pause();
    test_full_rate();

    // let the last characters drain, then a few spare cycles
    @(negedge clk_i);
    in_valid <= 1'b0;
    wait (escaped_chars.size() == 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, well beyond the slowest legal run
  initial begin
    #5000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
rtl/jue_pkg.sv
rtl/jue_front.sv
rtl/jue_queue.sv
rtl/jue_back.sv
rtl/json_utf8_string_escaper.sv
bench/tb_json_utf8_string_escaper.sv
